// ===== rtl/core/salsa_pkg.sv =====
// Shared constants, types and helper functions for the Salsa20 stream cipher.
package salsa_pkg;

	localparam int ROUNDS_DEFAULT = 20;
	localparam int BLOCK_BYTES    = 64;
	localparam int POS_W          = $clog2(BLOCK_BYTES);
	localparam int WORDS          = 16;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_W          = 64;

	localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_MIDLOW  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_MIDHIGH = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_NONCE       = 3'd4;

	typedef logic [31:0] word_t;

	// "expand 32-byte k"
	localparam word_t SIGMA0 = 32'h6170_7865;
	localparam word_t SIGMA1 = 32'h3320_646e;
	localparam word_t SIGMA2 = 32'h7962_2d32;
	localparam word_t SIGMA3 = 32'h6b20_6574;

	// Quarter-round word indices (a, b, c, d), four quarters per round.
	localparam logic [3:0] COL_IDX [WORDS] = '{
		4'd0,  4'd4,  4'd8,  4'd12,
		4'd5,  4'd9,  4'd13, 4'd1,
		4'd10, 4'd14, 4'd2,  4'd6,
		4'd15, 4'd3,  4'd7,  4'd11
	};
	localparam logic [3:0] ROW_IDX [WORDS] = '{
		4'd0,  4'd1,  4'd2,  4'd3,
		4'd5,  4'd6,  4'd7,  4'd4,
		4'd10, 4'd11, 4'd8,  4'd9,
		4'd15, 4'd12, 4'd13, 4'd14
	};

	typedef struct packed {
		logic             load;
		logic             step;
		logic             row;
		logic [1:0]       phase;
		logic             feed;
		logic             capture;
		logic             emit;
		logic             emit_live;
		logic [POS_W-1:0] pos;
	} salsa_cmd_t;

	// Rotate the quarter-round sum by the amount tied to each phase.
	function automatic word_t qr_rot(input word_t sum, input logic [1:0] phase);
		word_t r;
		case (phase)
			2'd0: r = {sum[24:0], sum[31:25]};
			2'd1: r = {sum[22:0], sum[31:23]};
			2'd2: r = {sum[18:0], sum[31:19]};
			2'd3: r = {sum[13:0], sum[31:14]};
			default: r = sum;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/core/salsa_if.sv =====
// Message and result channel interfaces for the Salsa20 stream cipher.
interface salsa_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       message_end;

	modport source(output valid, output data_byte, output message_end, input ready);
	modport sink(input valid, input data_byte, input message_end, output ready);
endinterface

interface salsa_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_last;

	modport source(output valid, output out_byte, output out_last, input ready);
	modport sink(input valid, input out_byte, input out_last, output ready);
endinterface

// ===== rtl/core/salsa_ctrl.sv =====
// Controller: byte position, round sequencing and request handshakes.
module salsa_ctrl #(
	parameter int ROUNDS = salsa_pkg::ROUNDS_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_hit,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                in_last,
	output logic                out_valid,
	input  logic                out_ready,
	output salsa_pkg::salsa_cmd_t cmd
);
	import salsa_pkg::*;

	localparam int RND_W    = $clog2(ROUNDS);
	// Whole double rounds only: an odd count drops its last single round.
	localparam int LAST_RND = 2 * (ROUNDS / 2) - 1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_FEED = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0]       state_q, state_d;
	logic [POS_W-1:0] pos_q, pos_d;
	logic [RND_W-1:0] round_q, round_d;
	logic [1:0]       phase_q, phase_d;
	logic             last_q, last_d;
	logic             out_valid_q;
	logic             out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d   = state_q;
		pos_d     = pos_q;
		round_d   = round_q;
		phase_d   = phase_q;
		last_d    = last_q;
		in_ready  = 1'b0;
		cmd       = '0;
		cmd.pos   = pos_q;
		cmd.row   = round_q[0];
		cmd.phase = phase_q;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (pos_q == '0) begin
						cmd.load    = 1'b1;
						cmd.capture = 1'b1;
						last_d      = in_last;
						round_d     = '0;
						phase_d     = 2'd0;
						state_d     = ST_RUN;
					end else if (out_free) begin
						cmd.emit      = 1'b1;
						cmd.emit_live = 1'b1;
						pos_d         = in_last ? '0 : pos_q + 1'b1;
					end else begin
						cmd.capture = 1'b1;
						last_d      = in_last;
						state_d     = ST_EMIT;
					end
				end
			end
			ST_RUN: begin
				cmd.step = 1'b1;
				phase_d  = phase_q + 2'd1;
				if (phase_q == 2'd3) begin
					if (round_q == RND_W'(LAST_RND)) begin
						state_d = ST_FEED;
					end else begin
						round_d = round_q + 1'b1;
					end
				end
			end
			ST_FEED: begin
				cmd.feed = 1'b1;
				state_d  = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free) begin
					cmd.emit = 1'b1;
					pos_d    = last_q ? '0 : pos_q + 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		if (cfg_hit) begin
			pos_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pos_q       <= '0;
			round_q     <= '0;
			phase_q     <= 2'd0;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pos_q   <= pos_d;
			round_q <= round_d;
			phase_q <= phase_d;
			last_q  <= last_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/core/salsa_dp.sv =====
// Datapath: key and nonce registers, block counter, working state and output register.
module salsa_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic                            cfg_hit,
	input  logic [salsa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [salsa_pkg::CFG_W-1:0]     cfg_data,
	input  salsa_pkg::salsa_cmd_t           cmd,
	input  logic [7:0]                      in_byte,
	input  logic                            in_last,
	output logic [7:0]                      out_byte,
	output logic                            out_last
);
	import salsa_pkg::*;

	logic [CFG_W-1:0] key_low_q, key_midlow_q, key_midhigh_q, key_high_q, nonce_q;
	logic [63:0]      counter_q;
	word_t            x_q    [WORDS];
	word_t            x_next [WORDS];
	word_t            s_w    [WORDS];
	logic [3:0]       dst    [4];
	word_t            mixed  [4];
	logic [7:0]       hold_byte_q;
	logic             hold_last_q;
	logic [7:0]       out_byte_q;
	logic             out_last_q;
	word_t            ks_word;
	logic [7:0]       ks_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q     <= '0;
			key_midlow_q  <= '0;
			key_midhigh_q <= '0;
			key_high_q    <= '0;
			nonce_q       <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_KEY_LOW:     key_low_q     <= cfg_data;
				CFG_KEY_MIDLOW:  key_midlow_q  <= cfg_data;
				CFG_KEY_MIDHIGH: key_midhigh_q <= cfg_data;
				CFG_KEY_HIGH:    key_high_q    <= cfg_data;
				CFG_NONCE:       nonce_q       <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_q <= '0;
		end else if (cfg_hit) begin
			counter_q <= '0;
		end else if (cmd.feed) begin
			counter_q <= counter_q + 64'd1;
		end
	end

	always_comb begin
		s_w[0]  = SIGMA0;
		s_w[1]  = key_low_q[31:0];
		s_w[2]  = key_low_q[63:32];
		s_w[3]  = key_midlow_q[31:0];
		s_w[4]  = key_midlow_q[63:32];
		s_w[5]  = SIGMA1;
		s_w[6]  = nonce_q[31:0];
		s_w[7]  = nonce_q[63:32];
		s_w[8]  = counter_q[31:0];
		s_w[9]  = counter_q[63:32];
		s_w[10] = SIGMA2;
		s_w[11] = key_midhigh_q[31:0];
		s_w[12] = key_midhigh_q[63:32];
		s_w[13] = key_high_q[31:0];
		s_w[14] = key_high_q[63:32];
		s_w[15] = SIGMA3;
	end

	// One quarter-round step for all four quarters of the current round.
	for (genvar q = 0; q < 4; q++) begin : g_qr
		logic [1:0] p_src2, p_dst;
		logic [3:0] a_idx, b_idx;
		assign p_src2 = cmd.phase + 2'd3;
		assign p_dst  = cmd.phase + 2'd1;
		assign a_idx  = cmd.row ? ROW_IDX[{2'(q), cmd.phase}] : COL_IDX[{2'(q), cmd.phase}];
		assign b_idx  = cmd.row ? ROW_IDX[{2'(q), p_src2}] : COL_IDX[{2'(q), p_src2}];
		assign dst[q] = cmd.row ? ROW_IDX[{2'(q), p_dst}] : COL_IDX[{2'(q), p_dst}];
		assign mixed[q] = x_q[dst[q]] ^ qr_rot(x_q[a_idx] + x_q[b_idx], cmd.phase);
	end

	always_comb begin
		x_next = x_q;
		for (int q = 0; q < 4; q++) begin
			x_next[dst[q]] = mixed[q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q <= s_w;
		end else if (cmd.step) begin
			x_q <= x_next;
		end else if (cmd.feed) begin
			for (int i = 0; i < WORDS; i++) begin
				x_q[i] <= x_q[i] + s_w[i];
			end
		end
	end

	assign ks_word = x_q[cmd.pos[POS_W-1:2]];
	assign ks_byte = 8'(ks_word >> {cmd.pos[1:0], 3'b000});

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			hold_byte_q <= in_byte;
			hold_last_q <= in_last;
		end
		if (cmd.emit) begin
			out_byte_q <= (cmd.emit_live ? in_byte : hold_byte_q) ^ ks_byte;
			out_last_q <= cmd.emit_live ? in_last : hold_last_q;
		end
	end

	assign out_byte = out_byte_q;
	assign out_last = out_last_q;

endmodule

// ===== rtl/core/salsa20_stream_cipher.sv =====
// Top level of the Salsa20 byte stream cipher.
//
//   channel  dir  payload                    handshake
//   msg      in   data_byte[8], message_end  valid/ready
//   crypt    out  out_byte[8], out_last      valid/ready
//   cfg      in   cfg_index[3], cfg_data[64] cfg_we (no ready)
//
// A byte inside a keystream block is accepted and, when the output register is
// free, its result lands there in the same cycle; else the byte is held first.
// A byte at block position 0 loads the working state, which advances one
// quarter-round step per cycle for ROUNDS rounded down to even rounds; a
// feed-forward step and an emit step follow.
// Reset clears keys, nonce, block counter and byte position; a write to any
// register also clears the counter and position. A stalled output keeps its
// result while the next request can still be accepted and held.
module salsa20_stream_cipher #(
	parameter int ROUNDS = salsa_pkg::ROUNDS_DEFAULT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [salsa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [salsa_pkg::CFG_W-1:0]     cfg_data,
	salsa_in_if.sink                        msg,
	salsa_out_if.source                     crypt
);
	import salsa_pkg::*;

	salsa_cmd_t cmd;
	logic       cfg_hit;

	// Only writes to a real register restart the keystream.
	assign cfg_hit = cfg_we && (cfg_index <= CFG_NONCE);

	salsa_ctrl #(
		.ROUNDS(ROUNDS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_hit  (cfg_hit),
		.in_valid (msg.valid),
		.in_ready (msg.ready),
		.in_last  (msg.message_end),
		.out_valid(crypt.valid),
		.out_ready(crypt.ready),
		.cmd      (cmd)
	);

	salsa_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_hit  (cfg_hit),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.in_byte  (msg.data_byte),
		.in_last  (msg.message_end),
		.out_byte (crypt.out_byte),
		.out_last (crypt.out_last)
	);

endmodule

// ===== tb/salsa20_stream_cipher_tb.sv =====
// Self-checking testbench for the Salsa20 byte stream cipher top level.
module salsa20_stream_cipher_tb;
	import salsa_pkg::*;

	// Scoreboard: tracks key, nonce, block counter and byte position, builds
	// each keystream block and holds the expected cipher bytes in order.
	class cipher_scoreboard;
		typedef struct packed {
			logic [7:0] data;
			logic       last;
		} crypt_result_t;

		bit [CFG_W-1:0]   cfg_regs[5];
		bit [63:0]        block_count;
		bit [POS_W-1:0]   position;
		bit [7:0]         keystream[BLOCK_BYTES];
		bit [31:0]        mix[WORDS];
		crypt_result_t    expected_q[$];
		int unsigned      mismatches;
		int unsigned      blocks_made;
		int unsigned      results_checked;

		function new();
			foreach (cfg_regs[i]) cfg_regs[i] = '0;
			block_count = '0;
			position = '0;
			mismatches = 0;
			blocks_made = 0;
			results_checked = 0;
		endfunction

		function void apply_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
			case (idx)
				CFG_KEY_LOW, CFG_KEY_MIDLOW, CFG_KEY_MIDHIGH, CFG_KEY_HIGH, CFG_NONCE: begin
					cfg_regs[idx] = value;
					block_count = '0;
					position = '0;
				end
				default: ;
			endcase
		endfunction

		function bit [31:0] rol32(bit [31:0] v, int unsigned n);
			return (v << n) | (v >> (32 - n));
		endfunction

		function void quarter(int a, int b, int c, int d);
			mix[b] ^= rol32(mix[a] + mix[d], 7);
			mix[c] ^= rol32(mix[b] + mix[a], 9);
			mix[d] ^= rol32(mix[c] + mix[b], 13);
			mix[a] ^= rol32(mix[d] + mix[c], 18);
		endfunction

		function void next_keystream_block();
			bit [31:0] init[WORDS];
			bit [31:0] w;
			init[0]  = SIGMA0;
			init[1]  = cfg_regs[CFG_KEY_LOW][31:0];
			init[2]  = cfg_regs[CFG_KEY_LOW][63:32];
			init[3]  = cfg_regs[CFG_KEY_MIDLOW][31:0];
			init[4]  = cfg_regs[CFG_KEY_MIDLOW][63:32];
			init[5]  = SIGMA1;
			init[6]  = cfg_regs[CFG_NONCE][31:0];
			init[7]  = cfg_regs[CFG_NONCE][63:32];
			init[8]  = block_count[31:0];
			init[9]  = block_count[63:32];
			init[10] = SIGMA2;
			init[11] = cfg_regs[CFG_KEY_MIDHIGH][31:0];
			init[12] = cfg_regs[CFG_KEY_MIDHIGH][63:32];
			init[13] = cfg_regs[CFG_KEY_HIGH][31:0];
			init[14] = cfg_regs[CFG_KEY_HIGH][63:32];
			init[15] = SIGMA3;
			mix = init;
			for (int r = 0; r < ROUNDS_DEFAULT / 2; r++) begin
				quarter(0, 4, 8, 12);
				quarter(5, 9, 13, 1);
				quarter(10, 14, 2, 6);
				quarter(15, 3, 7, 11);
				quarter(0, 1, 2, 3);
				quarter(5, 6, 7, 4);
				quarter(10, 11, 8, 9);
				quarter(15, 12, 13, 14);
			end
			for (int i = 0; i < WORDS; i++) begin
				w = mix[i] + init[i];
				for (int j = 0; j < 4; j++) keystream[4 * i + j] = w[8 * j +: 8];
			end
			block_count++;
			blocks_made++;
		endfunction

		function void note_request(logic [7:0] data, logic last);
			crypt_result_t r;
			if (position == 0) next_keystream_block();
			r.data = data ^ keystream[position];
			r.last = last;
			expected_q.push_back(r);
			position = last ? '0 : position + 1'b1;
		endfunction

		function void check_result(logic [7:0] data, logic last);
			crypt_result_t want;
			results_checked++;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: unexpected result byte %02h last %0b", data, last);
				return;
			end
			want = expected_q.pop_front();
			if (want.data !== data || want.last !== last) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: result %0d: expected byte %02h last %0b, got byte %02h last %0b",
						results_checked, want.data, want.last, data, last);
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	salsa_in_if  msg_if();
	salsa_out_if crypt_if();

	salsa20_stream_cipher i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.msg       (msg_if),
		.crypt     (crypt_if)
	);

	cipher_scoreboard sb;

	int unsigned burst_left;
	int unsigned bytes_sent;
	int unsigned messages_sent;
	int unsigned writes_done;
	bit          long_hold_req;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the block hangs somewhere.
	initial begin
		#10_000_000;
		$display("ERROR: timeout with %0d results still expected", sb.expected_q.size());
		$display("Test completed with failures");
		$finish;
	end

	// Pick the gap before a burst: mostly none or short, now and then about as long
	// as a whole keystream block computation.
	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 40) return 0;
		if (roll < 80) return $urandom_range(1, 6);
		if (roll < 95) return $urandom_range(7, 40);
		return $urandom_range(60, 120);
	endfunction

	// Offer one request and hold it until the block takes it. Between bursts,
	// drop valid for a random gap first.
	task automatic send_byte(input logic [7:0] b, input logic e);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = pick_gap();
			if (gap > 0) begin
				msg_if.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		msg_if.valid       <= 1'b1;
		msg_if.data_byte   <= b;
		msg_if.message_end <= e;
		@(posedge clk);
		while (!msg_if.ready) @(posedge clk);
		sb.note_request(b, e);
		bytes_sent++;
		if (e) messages_sent++;
	endtask

	// Drop valid, wait for every expected result, then a short settle.
	task automatic drain_pipeline();
		msg_if.valid <= 1'b0;
		burst_left = 0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Write one register; the write lands on the next rising edge.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		sb.apply_write(idx, value);
		cfg_we <= 1'b0;
		@(posedge clk);
		writes_done++;
	endtask

	function automatic logic [CFG_W-1:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// Random messages: mostly short, some within one block, a few longer than
	// a block. The final message of a run may end without its last flag; the next
	// run then carries on mid-block unless a key or nonce write intervenes.
	task automatic run_messages(input int unsigned n_items);
		int unsigned left;
		int unsigned len;
		int unsigned roll;
		left = n_items;
		while (left > 0) begin
			roll = $urandom_range(0, 99);
			if (roll < 70)
				len = $urandom_range(1, 16);
			else if (roll < 90)
				len = $urandom_range(17, 63);
			else
				len = $urandom_range(64, 140);
			for (int k = 0; k < len && left > 0; k++) begin
				send_byte(8'($urandom_range(0, 255)), k == len - 1);
				left--;
			end
		end
	endtask

	// Receiver: check each accepted result, then decide ready for the next
	// cycle. Stall modes change at random intervals; a long hold-off on
	// request lets the block fill up and push back on its input.
	initial begin : crypt_receiver
		int unsigned mode;
		int unsigned mode_left;
		int unsigned hold_left;
		mode = 0;
		mode_left = 0;
		hold_left = 0;
		crypt_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && crypt_if.valid === 1'b1 && crypt_if.ready)
				sb.check_result(crypt_if.out_byte, crypt_if.out_last);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				crypt_if.ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode = $urandom_range(0, 3);
					mode_left = $urandom_range(10, 80);
				end
				mode_left--;
				case (mode)
					0: crypt_if.ready <= 1'b1;
					1: crypt_if.ready <= 1'($urandom_range(0, 1));
					2: crypt_if.ready <= ($urandom_range(0, 3) == 0);
					default: crypt_if.ready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	initial begin : stimulus
		sb = new();
		burst_left = 0;
		bytes_sent = 0;
		messages_sent = 0;
		writes_done = 0;
		long_hold_req = 1'b0;
		arst_n             <= 1'b0;
		cfg_we             <= 1'b0;
		cfg_index          <= CFG_KEY_LOW;
		cfg_data           <= '0;
		msg_if.valid       <= 1'b0;
		msg_if.data_byte   <= '0;
		msg_if.message_end <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed, reset key and nonce. One-byte messages at block start
		// with the byte extremes: each forces a fresh block.
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b1);
		// End inside a block: the rest of the block is thrown away.
		send_byte(8'h55, 1'b0);
		send_byte(8'hAA, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h0F, 1'b0);
		send_byte(8'hF0, 1'b0);
		send_byte(8'h3C, 1'b1);
		// Walk a single one across the data byte.
		for (int i = 0; i < 8; i++) send_byte(8'(1 << i), i == 7);
		drain_pipeline();

		// Random part: six key/nonce settings, extremes among them.
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin
					// all ones everywhere
					write_reg(CFG_KEY_LOW, '1);
					write_reg(CFG_KEY_MIDLOW, '1);
					write_reg(CFG_KEY_MIDHIGH, '1);
					write_reg(CFG_KEY_HIGH, '1);
					write_reg(CFG_NONCE, '1);
				end
				1, 5: begin
					write_reg(CFG_NONCE, rand64());
					write_reg(CFG_KEY_HIGH, rand64());
					write_reg(CFG_KEY_MIDHIGH, rand64());
					write_reg(CFG_KEY_MIDLOW, rand64());
					write_reg(CFG_KEY_LOW, rand64());
				end
				2: begin
					// keep the key, change the nonce; stall the output hard
					write_reg(CFG_NONCE, rand64());
					long_hold_req = 1'b1;
				end
				3: begin
					write_reg(CFG_KEY_LOW, '0);
					write_reg(CFG_KEY_MIDLOW, '0);
					write_reg(CFG_KEY_MIDHIGH, '0);
					write_reg(CFG_KEY_HIGH, '0);
					write_reg(CFG_NONCE, '1);
				end
				default: write_reg(CFG_KEY_MIDHIGH, rand64());
			endcase
			if (ph == 4) begin
				// Writes to unused indexes must leave counter and position alone,
				// so the stream picks up mid-block where it stopped.
				run_messages(37);
				drain_pipeline();
				for (int i = int'(CFG_NONCE) + 1; i < (1 << CFG_IDX_W); i++)
					write_reg(CFG_IDX_W'(i), rand64());
				run_messages(38);
			end else begin
				run_messages(75);
			end
			drain_pipeline();
		end

		repeat (100) @(posedge clk);
		if (sb.expected_q.size() != 0) begin
			sb.mismatches++;
			$display("ERROR: %0d results never arrived", sb.expected_q.size());
		end
		$display("Coverage: %0d bytes, %0d complete messages, %0d register writes, %0d keystream blocks",
			bytes_sent, messages_sent, writes_done, sb.blocks_made);
		$display("Checked %0d results, %0d mismatches", sb.results_checked, sb.mismatches);
		if (sb.mismatches == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
